// ===== rtl/core/assert_macros.svh =====
// Assertion helpers, clocked on clk_i and disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define MCMC_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MCMC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/mcmc_pkg.sv =====
`timescale 1ns / 1ps

package mcmc_pkg;

  localparam int MAX_MATRICES = 64;
  localparam int DIM_WIDTH    = 16;
  localparam int DIM_DEPTH    = MAX_MATRICES + 1;
  localparam int COST_DEPTH   = MAX_MATRICES * MAX_MATRICES;

  localparam int DIM_FIELD_W  = 16;
  localparam int COST_W       = 54;
  localparam int SPLIT_W      = 6;
  localparam int STATUS_W     = 2;
  localparam int IN_TDATA_W   = ((DIM_FIELD_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W  = ((COST_W + SPLIT_W + 7) / 8) * 8;

  localparam int IDX_W        = $clog2(MAX_MATRICES);
  localparam int CNT_W        = $clog2(DIM_DEPTH + 1);
  localparam int DADDR_W      = $clog2(DIM_DEPTH);
  localparam int COST_AW      = $clog2(COST_DEPTH);
  localparam int PAB_W        = 2 * DIM_WIDTH;
  localparam int PROD_W       = 3 * DIM_WIDTH;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK,
    STATUS_SHORT,
    STATUS_LONG
  } status_e;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_RD_A,
    ST_RD_B,
    ST_MUL,
    ST_ISSUE,
    ST_DRAIN,
    ST_NEXT,
    ST_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic               dim_we;
    logic [DADDR_W-1:0] dim_waddr;
    logic [DADDR_W-1:0] dim_raddr;
    logic               pa_load;
    logic               pab_load;
    logic               issue;
    logic               first;
    logic               zero_b;
    logic [IDX_W-1:0]   row;
    logic [IDX_W-1:0]   col;
    logic [IDX_W-1:0]   k;
    logic               cost_we;
    logic               out_load;
    logic               out_zero;
    status_e            out_status;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
  } dp_sts_t;

endpackage

// ===== rtl/core/mcmc_datapath.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mcmc_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mcmc_pkg::dp_cmd_t                   cmd_i,
  input  logic [mcmc_pkg::DIM_WIDTH-1:0]      dim_i,
  output mcmc_pkg::dp_sts_t                   sts_o,
  output logic [mcmc_pkg::COST_W-1:0]         min_cost_o,
  output logic [mcmc_pkg::SPLIT_W-1:0]        best_split_o,
  output mcmc_pkg::status_e                   status_o
);

  logic [mcmc_pkg::DIM_WIDTH-1:0] dim_mem [mcmc_pkg::DIM_DEPTH];
  logic [mcmc_pkg::COST_W-1:0]    cost_mem [mcmc_pkg::COST_DEPTH];

  logic [mcmc_pkg::DIM_WIDTH-1:0] dim_rd_q;
  logic [mcmc_pkg::COST_W-1:0]    cost_a_q;
  logic [mcmc_pkg::COST_W-1:0]    cost_b_q;
  logic [mcmc_pkg::COST_AW-1:0]   raddr_a;
  logic [mcmc_pkg::COST_AW-1:0]   raddr_b;
  logic [mcmc_pkg::COST_AW-1:0]   waddr;

  logic [mcmc_pkg::DIM_WIDTH-1:0] pa_q;
  logic [mcmc_pkg::PAB_W-1:0]     pab_q;

  logic                           v1_q, v2_q;
  logic                           first1_q, zero_a1_q, zero_b1_q, first2_q;
  logic [mcmc_pkg::IDX_W-1:0]     k1_q, k2_q;
  logic [mcmc_pkg::COST_W-1:0]    sum2_q;
  logic [mcmc_pkg::PROD_W-1:0]    prod2_q;
  logic [mcmc_pkg::COST_W-1:0]    sum_d;
  logic [mcmc_pkg::PROD_W-1:0]    prod_d;
  logic [mcmc_pkg::COST_W-1:0]    q;

  logic [mcmc_pkg::COST_W-1:0]    best_q;
  logic [mcmc_pkg::IDX_W-1:0]     where_q;

  logic [mcmc_pkg::COST_W-1:0]    min_cost_q;
  logic [mcmc_pkg::SPLIT_W-1:0]   best_split_q;
  mcmc_pkg::status_e              status_q;

  // m[a][k] and m[k+1][b]
  assign raddr_a = mcmc_pkg::COST_AW'(cmd_i.row) * mcmc_pkg::COST_AW'(mcmc_pkg::MAX_MATRICES)
                 + mcmc_pkg::COST_AW'(cmd_i.k);
  assign raddr_b = (mcmc_pkg::COST_AW'(cmd_i.k) + mcmc_pkg::COST_AW'(1))
                 * mcmc_pkg::COST_AW'(mcmc_pkg::MAX_MATRICES)
                 + mcmc_pkg::COST_AW'(cmd_i.col);
  assign waddr   = mcmc_pkg::COST_AW'(cmd_i.row) * mcmc_pkg::COST_AW'(mcmc_pkg::MAX_MATRICES)
                 + mcmc_pkg::COST_AW'(cmd_i.col);

  always_ff @(posedge clk_i) begin
    if (cmd_i.dim_we) begin
      dim_mem[cmd_i.dim_waddr] <= dim_i;
    end
    dim_rd_q <= dim_mem[cmd_i.dim_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cost_we) begin
      cost_mem[waddr] <= best_q;
    end
    cost_a_q <= cost_mem[raddr_a];
    cost_b_q <= cost_mem[raddr_b];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pa_load) begin
      pa_q <= dim_rd_q;
    end
    if (cmd_i.pab_load) begin
      pab_q <= mcmc_pkg::PAB_W'(pa_q) * mcmc_pkg::PAB_W'(dim_rd_q);
    end
  end

  // diagonal cells are zero and never stored
  assign sum_d  = (zero_a1_q ? '0 : cost_a_q) + (zero_b1_q ? '0 : cost_b_q);
  assign prod_d = mcmc_pkg::PROD_W'(pab_q) * mcmc_pkg::PROD_W'(dim_rd_q);
  assign q      = sum2_q + mcmc_pkg::COST_W'(prod2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    first1_q  <= cmd_i.first;
    zero_a1_q <= cmd_i.first;
    zero_b1_q <= cmd_i.zero_b;
    k1_q      <= cmd_i.k;
    first2_q  <= first1_q;
    k2_q      <= k1_q;
    sum2_q    <= sum_d;
    prod2_q   <= prod_d;
    if (v2_q && (first2_q || (q < best_q))) begin
      best_q  <= q;
      where_q <= k2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      status_q <= cmd_i.out_status;
      if (cmd_i.out_zero) begin
        min_cost_q   <= '0;
        best_split_q <= '0;
      end else begin
        min_cost_q   <= best_q;
        best_split_q <= mcmc_pkg::SPLIT_W'(where_q + mcmc_pkg::IDX_W'(1));
      end
    end
  end

  assign sts_o.busy   = v1_q | v2_q;
  assign min_cost_o   = min_cost_q;
  assign best_split_o = best_split_q;
  assign status_o     = status_q;

  `MCMC_ASSERT_IMPLY(a_write_drained, cmd_i.cost_we, !v1_q && !v2_q && !cmd_i.issue,
                     "cost write while products still in flight")

endmodule

// ===== rtl/core/mcmc_ctrl.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mcmc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  input  logic                s_last_i,
  output logic                s_ready_o,
  output logic                m_valid_o,
  input  logic                m_ready_i,
  output mcmc_pkg::dp_cmd_t   cmd_o,
  input  mcmc_pkg::dp_sts_t   sts_i
);

  mcmc_pkg::ctrl_state_e         state_q, state_d;
  logic [mcmc_pkg::CNT_W-1:0]    cnt_q, cnt_d;
  logic                          ovf_q, ovf_d;
  logic [mcmc_pkg::CNT_W-1:0]    n_q, n_d;
  logic [mcmc_pkg::CNT_W-1:0]    len_q, len_d;
  logic [mcmc_pkg::IDX_W-1:0]    a_q, a_d;
  logic [mcmc_pkg::IDX_W-1:0]    k_q, k_d;
  mcmc_pkg::status_e             status_q, status_d;
  logic                          out_valid_q, out_valid_d;

  logic                          accept;
  logic                          has_room;
  logic [mcmc_pkg::CNT_W-1:0]    cnt_inc;
  logic                          ovf_nx;
  mcmc_pkg::status_e             status_nx;
  logic                          go_fill;
  logic [mcmc_pkg::IDX_W-1:0]    b;
  logic                          last_k;
  logic                          a_last;
  logic                          len_last;
  logic                          out_free;

  assign accept    = s_valid_i && (state_q == mcmc_pkg::ST_LOAD);
  assign has_room  = cnt_q < mcmc_pkg::CNT_W'(mcmc_pkg::DIM_DEPTH);
  assign cnt_inc   = cnt_q + mcmc_pkg::CNT_W'(has_room);
  assign ovf_nx    = ovf_q || !has_room;
  assign status_nx = ovf_nx ? mcmc_pkg::STATUS_LONG :
                     (cnt_inc < mcmc_pkg::CNT_W'(2)) ? mcmc_pkg::STATUS_SHORT :
                     mcmc_pkg::STATUS_OK;
  // two dimensions is a single matrix: nothing to fill
  assign go_fill   = (status_nx == mcmc_pkg::STATUS_OK) && (cnt_inc > mcmc_pkg::CNT_W'(2));
  assign b         = mcmc_pkg::IDX_W'(mcmc_pkg::CNT_W'(a_q) + len_q - mcmc_pkg::CNT_W'(1));
  assign last_k    = (k_q == b - mcmc_pkg::IDX_W'(1));
  assign a_last    = (mcmc_pkg::CNT_W'(a_q) + len_q) >= n_q;
  assign len_last  = len_q >= n_q;
  assign out_free  = !out_valid_q || m_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      mcmc_pkg::ST_LOAD: begin
        if (accept && s_last_i) begin
          state_d = go_fill ? mcmc_pkg::ST_RD_A : mcmc_pkg::ST_DONE;
        end
      end
      mcmc_pkg::ST_RD_A:  state_d = mcmc_pkg::ST_RD_B;
      mcmc_pkg::ST_RD_B:  state_d = mcmc_pkg::ST_MUL;
      mcmc_pkg::ST_MUL:   state_d = mcmc_pkg::ST_ISSUE;
      mcmc_pkg::ST_ISSUE: begin
        if (last_k) begin
          state_d = mcmc_pkg::ST_DRAIN;
        end
      end
      mcmc_pkg::ST_DRAIN: begin
        if (!sts_i.busy) begin
          state_d = mcmc_pkg::ST_NEXT;
        end
      end
      mcmc_pkg::ST_NEXT: begin
        state_d = (a_last && len_last) ? mcmc_pkg::ST_DONE : mcmc_pkg::ST_RD_A;
      end
      mcmc_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = mcmc_pkg::ST_LOAD;
        end
      end
      default: state_d = mcmc_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    n_d         = n_q;
    len_d       = len_q;
    a_d         = a_q;
    k_d         = k_q;
    status_d    = status_q;
    out_valid_d = out_valid_q;
    if (m_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      mcmc_pkg::ST_LOAD: begin
        if (accept) begin
          cnt_d = cnt_inc;
          ovf_d = ovf_nx;
          if (s_last_i) begin
            cnt_d    = '0;
            ovf_d    = 1'b0;
            n_d      = cnt_inc - mcmc_pkg::CNT_W'(1);
            status_d = status_nx;
            len_d    = mcmc_pkg::CNT_W'(2);
            a_d      = '0;
          end
        end
      end
      mcmc_pkg::ST_RD_A:  k_d = a_q;
      mcmc_pkg::ST_ISSUE: k_d = k_q + mcmc_pkg::IDX_W'(1);
      mcmc_pkg::ST_NEXT: begin
        if (a_last) begin
          a_d   = '0;
          len_d = len_q + mcmc_pkg::CNT_W'(1);
        end else begin
          a_d = a_q + mcmc_pkg::IDX_W'(1);
        end
      end
      mcmc_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.dim_we     = accept && has_room;
    cmd_o.dim_waddr  = mcmc_pkg::DADDR_W'(cnt_q);
    cmd_o.dim_raddr  = mcmc_pkg::DADDR_W'(a_q);
    cmd_o.row        = a_q;
    cmd_o.col        = b;
    cmd_o.k          = k_q;
    cmd_o.first      = (k_q == a_q);
    cmd_o.zero_b     = last_k;
    cmd_o.out_status = status_q;
    cmd_o.out_zero   = (status_q != mcmc_pkg::STATUS_OK) || (n_q == mcmc_pkg::CNT_W'(1));
    case (state_q)
      mcmc_pkg::ST_RD_B: begin
        cmd_o.dim_raddr = mcmc_pkg::DADDR_W'(b) + mcmc_pkg::DADDR_W'(1);
        cmd_o.pa_load   = 1'b1;
      end
      mcmc_pkg::ST_MUL:   cmd_o.pab_load = 1'b1;
      mcmc_pkg::ST_ISSUE: begin
        cmd_o.dim_raddr = mcmc_pkg::DADDR_W'(k_q) + mcmc_pkg::DADDR_W'(1);
        cmd_o.issue     = 1'b1;
      end
      mcmc_pkg::ST_DRAIN: cmd_o.cost_we  = !sts_i.busy;
      mcmc_pkg::ST_DONE:  cmd_o.out_load = out_free;
      default: ;
    endcase
  end

  assign s_ready_o = (state_q == mcmc_pkg::ST_LOAD);
  assign m_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mcmc_pkg::ST_LOAD;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      n_q         <= '0;
      len_q       <= '0;
      a_q         <= '0;
      k_q         <= '0;
      status_q    <= mcmc_pkg::STATUS_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      n_q         <= n_d;
      len_q       <= len_d;
      a_q         <= a_d;
      k_q         <= k_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

  `MCMC_ASSERT_IMPLY(a_issue_range, state_q == mcmc_pkg::ST_ISSUE, (k_q >= a_q) && (k_q < b),
                     "split index outside its cell")
  `MCMC_ASSERT_IMPLY(a_setup_idle, state_q == mcmc_pkg::ST_RD_A, !sts_i.busy,
                     "new cell started with products in flight")
  `MCMC_ASSERT_IMPLY(a_cell_inside, state_q == mcmc_pkg::ST_RD_A,
                     (len_q >= mcmc_pkg::CNT_W'(2)) && (mcmc_pkg::CNT_W'(a_q) + len_q <= n_q),
                     "cell outside the chain")

endmodule

// ===== rtl/core/matrix_chain_min_cost_core.sv =====
`timescale 1ns / 1ps
// Matrix chain ordering: minimum scalar multiplication count and outer split.
// Input stream: one dimension p[i] per word in chain order; tlast marks the
// final dimension and starts the fill. While loading, a word is taken on
// every tvalid. After the last word, input tready stays low while the cost
// table is filled by chain length. Each cell of chain length len reads p[a]
// and p[b+1] and multiplies them, issues one product per split through the
// cost RAM's two read ports, then drains and writes the cell. Short, overlong
// or single-matrix lists skip the fill and go straight to the output.
// Output stream: one word per list with min_cost and best_split in tdata and
// the status code in tuser. The result sits in an output register: a stalled
// receiver holds it while the next list loads and even fills; only the next
// result waits for it to be taken.
// Reset clears the dimension count and the error flag and drops any pending
// result; table and dimension RAMs are not cleared.
module matrix_chain_min_cost_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [mcmc_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,   // [15:0] dimension
  input  logic                                s_axis_tlast_i,   // last
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [mcmc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,   // [53:0] min_cost, [59:54] best_split
  output logic [mcmc_pkg::STATUS_W-1:0]       m_axis_tuser_o    // [1:0] status
);

  mcmc_pkg::dp_cmd_t              cmd;
  mcmc_pkg::dp_sts_t              sts;
  logic [mcmc_pkg::COST_W-1:0]    min_cost;
  logic [mcmc_pkg::SPLIT_W-1:0]   best_split;
  mcmc_pkg::status_e              status;

  mcmc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_last_i  (s_axis_tlast_i),
    .s_ready_o (s_axis_tready_o),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .cmd_o     (cmd),
    .sts_i     (sts)
  );

  mcmc_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .dim_i        (s_axis_tdata_i[mcmc_pkg::DIM_WIDTH-1:0]),
    .sts_o        (sts),
    .min_cost_o   (min_cost),
    .best_split_o (best_split),
    .status_o     (status)
  );

  assign m_axis_tdata_o = {{(mcmc_pkg::OUT_TDATA_W - mcmc_pkg::COST_W - mcmc_pkg::SPLIT_W){1'b0}},
                           best_split, min_cost};
  assign m_axis_tuser_o = status;

endmodule
